### hw/rtl/srcd_pkg.sv
// package: item types, marker codes and result kinds of the sector read command deframer
package srcd_pkg;

  localparam int DEFAULT_CAPTURE_DEPTH = 15;

  localparam logic [7:0] MARK_START = 8'hDE;
  localparam logic [7:0] MARK_OPEN  = 8'hAD;
  localparam logic [7:0] MARK_CLOSE = 8'hBE;
  localparam logic [7:0] CMD_READ   = 8'h72;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_UNKNOWN  = 2'd1,
    KIND_OVERFLOW = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_start;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  command_code;
    logic [31:0] sector_number;
    logic [31:0] sector_total;
  } res_item_t;

  // what the frame core says about the item it is looking at
  typedef struct packed {
    logic      emit;
    res_item_t item;
  } core_res_t;

endpackage

### hw/rtl/srcd_frame_core.sv
// frame core: marker decode, capture position, capture store and result build
module srcd_frame_core #(
  parameter int CAPTURE_DEPTH = srcd_pkg::DEFAULT_CAPTURE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  srcd_pkg::rx_item_t  item,
  output srcd_pkg::core_res_t res
);
  import srcd_pkg::*;

  localparam int PosW = $clog2(CAPTURE_DEPTH);

  logic            start_armed, start_armed_next;
  logic            in_frame, in_frame_next;
  logic [PosW-1:0] capture_pos, capture_pos_next;
  logic [PosW-1:0] pos_base;
  logic            store_we;
  logic [7:0]      capture_store [CAPTURE_DEPTH];

  assign pos_base = item.chunk_start ? '0 : capture_pos;

  always_comb begin
    start_armed_next = start_armed;
    in_frame_next    = in_frame;
    capture_pos_next = pos_base;
    store_we         = 1'b0;
    res              = '0;
    if (item.rx_byte == MARK_START) begin
      start_armed_next = 1'b1;
    end else if (item.rx_byte == MARK_OPEN && start_armed) begin
      in_frame_next = 1'b1;
    end else if (item.rx_byte == MARK_CLOSE && in_frame) begin
      res.emit = 1'b1;
      res.item.result_kind   = (capture_store[0] == CMD_READ) ? KIND_READ : KIND_UNKNOWN;
      res.item.command_code  = capture_store[0];
      res.item.sector_number = {capture_store[5], capture_store[6],
                                capture_store[7], capture_store[8]};
      res.item.sector_total  = {capture_store[9], capture_store[10],
                                capture_store[11], capture_store[12]};
      start_armed_next = 1'b0;
      in_frame_next    = 1'b0;
      capture_pos_next = '0;
    end else if (in_frame) begin
      store_we = 1'b1;
      if (pos_base == PosW'(CAPTURE_DEPTH - 1)) begin
        // store full: report overflow, frame stays open
        res.emit = 1'b1;
        res.item.result_kind = KIND_OVERFLOW;
        capture_pos_next = '0;
      end else begin
        capture_pos_next = pos_base + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_armed <= 1'b0;
      in_frame    <= 1'b0;
      capture_pos <= '0;
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        capture_store[i] <= '0;
      end
    end else if (fire) begin
      start_armed <= start_armed_next;
      in_frame    <= in_frame_next;
      capture_pos <= capture_pos_next;
      if (store_we) begin
        capture_store[pos_base] <= item.rx_byte;
      end
    end
  end

endmodule

### hw/rtl/sector_read_command_deframer_unit.sv
// top level: input register, frame core and result register of the command deframer
//
//  channel | signals                         | direction | payload
//  rx      | rx_valid rx_ready rx_item       | in        | rx_item_t  (rx_byte, chunk_start)
//  res     | res_valid res_ready res_item    | out       | res_item_t (kind, code, sector, total)
//
// one item per cycle unless a result stalls; a result goes via input and result registers
// the frame core decodes the item held in the input register combinationally
// an item that makes a result waits in the input register while a result is held unread
// items that make no result pass on regardless of res_ready
// reset (rst, synchronous) clears flags, capture position and the whole capture store
module sector_read_command_deframer_unit #(
  parameter int CAPTURE_DEPTH = srcd_pkg::DEFAULT_CAPTURE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  srcd_pkg::rx_item_t  rx_item,
  output logic                res_valid,
  input  logic                res_ready,
  output srcd_pkg::res_item_t res_item
);
  import srcd_pkg::*;

  logic      hold_valid;
  rx_item_t  hold_item;
  core_res_t core_res;
  logic      hold_fire;

  srcd_frame_core #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (hold_fire),
    .item (hold_item),
    .res  (core_res)
  );

  assign hold_fire = hold_valid && (!res_valid || res_ready || !core_res.emit);
  assign rx_ready  = !hold_valid || hold_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_ready) begin
      hold_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      hold_item <= rx_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (hold_fire && core_res.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire && core_res.emit) begin
      res_item <= core_res.item;
    end
  end

endmodule

### hw/rtl/srcd_checker.sv
// checker on the deframer's ports, bound to the top level
module srcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                rx_valid,
  input logic                rx_ready,
  input srcd_pkg::rx_item_t  rx_item,
  input logic                res_valid,
  input logic                res_ready,
  input srcd_pkg::res_item_t res_item
);
  import srcd_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  // nothing is shown the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.result_kind == KIND_OVERFLOW |->
      res_item.command_code == 8'd0 && res_item.sector_number == 32'd0 &&
      res_item.sector_total == 32'd0)
    else $error("overflow item carries nonzero fields");

  // kind follows the command byte for frame closes
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.result_kind != KIND_OVERFLOW |->
      (res_item.result_kind == KIND_READ) == (res_item.command_code == CMD_READ))
    else $error("result kind does not match command byte");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.result_kind == KIND_READ ||
      res_item.result_kind == KIND_UNKNOWN || res_item.result_kind == KIND_OVERFLOW)
    else $error("unused result kind");

endmodule

bind sector_read_command_deframer_unit srcd_checker u_srcd_checker (.*);
